>>> rtl/mia_pkg.sv
// Shared constants and control types for the adjugate matrix inverter.
// No dependencies; imported by every module of the block.
package mia_pkg;

  localparam int MAX_ORDER_DEFAULT = 4;
  localparam int LIMB_W            = 32;
  localparam int ELEM_W            = 32;
  localparam int IDX_OUT_W         = 2;
  localparam int OUT_TDATA_W       = ((ELEM_W + 2 * IDX_OUT_W + 7) / 8) * 8;
  localparam int ORDER_W           = 3;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;
  localparam int REG_MATRIX_ORDER  = 0;

  typedef struct packed {
    logic start;
    logic flip;
  } div_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [ELEM_W-1:0] quotient;
  } div_result_t;

endpackage

>>> rtl/mia_limb_cell.sv
// One 32-bit limb of the product chain: loads a start value or takes its
// upper neighbor's limb. Depends on mia_pkg.
module mia_limb_cell import mia_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic [LIMB_W-1:0] load_value,
  input  logic              shift,
  input  logic [LIMB_W-1:0] shift_in,
  output logic [LIMB_W-1:0] limb
);

  always_ff @(posedge clk) begin
    if (load) begin
      limb <= load_value;
    end else if (shift) begin
      limb <= shift_in;
    end
  end

endmodule

>>> rtl/mia_divider.sv
// Restoring divider: saturated signed quotient of (num * 2^32) / den.
// Depends on mia_pkg for the control and result structs.
module mia_divider import mia_pkg::*; #(
  parameter int W = 224
) (
  input  logic        clk,
  input  logic        rst,
  input  div_ctrl_t   ctrl,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output div_result_t res
);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_RUN   = 2'd2;
  localparam logic [1:0] D_FIN   = 2'd3;
  localparam int SW = $clog2(ELEM_W);

  logic [1:0]        state;
  logic [W-1:0]      rem;
  logic [W-1:0]      dvs;
  logic [W-1:0]      rem2;
  logic [ELEM_W-1:0] quo;
  logic [ELEM_W-1:0] sat_val;
  logic [SW-1:0]     step;
  logic              neg;
  logic              high;

  // magnitudes stay below 2^(W-1), so doubling never loses the top bit
  assign rem2 = {rem[W-2:0], 1'b0};

  always_comb begin
    if (!neg) begin
      sat_val = (high || quo[ELEM_W-1]) ? {1'b0, {(ELEM_W-1){1'b1}}} : quo;
    end else if (high || (quo > {1'b1, {(ELEM_W-1){1'b0}}})) begin
      sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_val = ~quo + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (ctrl.start) begin
            rem   <= num[W-1] ? -num : num;
            dvs   <= den[W-1] ? -den : den;
            neg   <= num[W-1] ^ den[W-1] ^ ctrl.flip;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          // |num| >= |den| means the quotient needs more than 32 bits
          high  <= (rem >= dvs);
          quo   <= '0;
          step  <= '0;
          state <= (rem >= dvs) ? D_FIN : D_RUN;
        end
        D_RUN: begin
          if (rem2 >= dvs) begin
            rem <= rem2 - dvs;
            quo <= {quo[ELEM_W-2:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[ELEM_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == SW'(ELEM_W - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          res.done     <= 1'b1;
          res.quotient <= sat_val;
          state        <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/matrix_inverse_by_adjugate.sv
// Matrix inverse by adjugate: sequencer, element store, limb chain and divider.
// Depends on mia_pkg, mia_limb_cell and mia_divider.
//
// Usage: matrix elements (signed Q16.16) enter on s_tvalid/s_tready/s_tdata
// in row-major order, one per cycle while loading. After the n*n-th item the
// block stops taking input, computes the determinant and every cofactor by
// permutation expansion, divides each by the determinant and returns the
// inverse row-major on m_tvalid/m_tready/m_tdata, with m_tuser = singular
// and m_tlast on the final entry; a singular matrix skips the cofactors and
// gives all-zero entries. The order n is set through the APB port
// (register 0, reset 4, clamped to 2..MAX_ORDER). Each factor passes the
// single 32x32 multiplier at the head of the limb chain once per limb, and
// each cofactor then goes through the divider. One matrix is handled at a time.
// When the receiver stalls, the held entry stays on m_tdata and work waits.
// Reset clears control state and sets the order to 4; the store holds no
// valid data until loaded.
module matrix_inverse_by_adjugate import mia_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [ELEM_W-1:0]      s_tdata,   // [31:0] element_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] inverse_entry, [33:32] entry_row,
                                            // [35:34] entry_column, rest zero
  output logic                   m_tlast,
  output logic [0:0]             m_tuser,   // [0] singular
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int LIMBS = MAX_ORDER + 3;
  localparam int W     = LIMBS * LIMB_W;
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = $clog2(MAX_ORDER);
  localparam int CIDX  = $clog2(CELLS);
  localparam int LCW   = $clog2(CELLS + 1);
  localparam int MCW   = $clog2(LIMBS);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MINOR = 4'd1;
  localparam logic [3:0] S_TERM  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_FACT  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]          state;
  logic [ORDER_W-1:0]  order;
  logic [NW-1:0]       n_eff;
  logic [NW-1:0]       n_run;
  logic [NW-1:0]       msize;
  logic [NW-1:0]       skip_row;
  logic [NW-1:0]       skip_col;
  logic [NW-1:0]       level;
  logic [NW-1:0]       row;
  logic [CW-1:0]       col;
  logic [CW-1:0]       ei;
  logic [CW-1:0]       ej;
  logic [CW-1:0]       ei_next;
  logic [CW-1:0]       ej_next;
  logic [CW-1:0]       dig      [MAX_ORDER];
  logic [CW-1:0]       dig_next [MAX_ORDER];
  logic [CW:0]         seen;
  logic                found;
  logic                carry;
  logic                wrap;
  logic                parity;
  logic [MAX_ORDER-1:0] used;
  logic [ELEM_W-1:0]   store [CELLS];
  logic [ELEM_W-1:0]   elem;
  logic [LCW-1:0]      load_count;
  logic [LCW-1:0]      lc_eff;
  logic [LCW-1:0]      lc_inc;
  logic [LCW-1:0]      total;
  logic [2*NW-1:0]     addr_full;
  logic [CIDX-1:0]     addr;
  logic                is_det;
  logic                sing;
  logic                term_neg;
  logic                last_out;
  logic                in_acc;
  logic                cfg_wr;
  logic [LIMB_W-1:0]   limb [LIMBS];
  logic [LIMB_W-1:0]   mul_u;
  logic [LIMB_W-1:0]   mul_carry;
  logic [2*LIMB_W-1:0] head;
  logic [MCW-1:0]      mcnt;
  logic [W-1:0]        prod_wide;
  logic [W-1:0]        sum;
  logic [W-1:0]        det;
  logic [ELEM_W-1:0]   out_value;
  div_ctrl_t           dctl;
  div_result_t         dres;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'(REG_MATRIX_ORDER));
  assign prdata = (paddr[2] == 1'(REG_MATRIX_ORDER)) ? {(32 - ORDER_W)'(0), order} : '0;

  always_comb begin
    if (int'(order) < 2) begin
      n_eff = NW'(2);
    end else if (int'(order) > MAX_ORDER) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(order);
    end
  end

  // loading
  assign s_tready = (state == S_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign total    = LCW'(n_eff) * LCW'(n_eff);
  assign lc_eff   = (load_count >= LCW'(CELLS)) ? '0 : load_count;
  assign lc_inc   = lc_eff + 1'b1;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[lc_eff[CIDX-1:0]] <= s_tdata;
    end
    if (state == S_READ) begin
      elem <= store[addr];
    end
  end

  // row and column of the current factor; Lehmer digit picks the column
  assign row       = (level < skip_row) ? level : level + 1'b1;
  assign addr_full = (2*NW)'(row) * (2*NW)'(n_run) + (2*NW)'(col);
  assign addr      = addr_full[CIDX-1:0];

  always_comb begin
    seen  = '0;
    found = 1'b0;
    col   = '0;
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (c < int'(n_run) && c != int'(skip_col) && !used[c]) begin
        if (!found && seen == {1'b0, dig[level[CW-1:0]]}) begin
          col   = CW'(c);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
  end

  // mixed-radix step to the next permutation; digit parity is its sign
  always_comb begin
    carry  = 1'b1;
    parity = 1'b0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      dig_next[k] = dig[k];
      parity      = parity ^ dig[k][0];
    end
    for (int k = MAX_ORDER - 1; k >= 0; k--) begin
      if (carry && k < int'(msize)) begin
        if (int'(dig[k]) == int'(msize) - 1 - k) begin
          dig_next[k] = '0;
        end else begin
          dig_next[k] = dig[k] + 1'b1;
          carry       = 1'b0;
        end
      end
    end
    wrap = carry;
  end

  // limb chain: product magnitude rotates through the multiplier, low limb first
  assign head = {LIMB_W'(0), limb[0]} * {LIMB_W'(0), mul_u} + {LIMB_W'(0), mul_carry};

  for (genvar k = 0; k < LIMBS; k++) begin : g_chain
    logic [LIMB_W-1:0] from_next;
    if (k == LIMBS - 1) begin : g_tail
      assign from_next = head[LIMB_W-1:0];
    end else begin : g_mid
      assign from_next = limb[k+1];
    end
    mia_limb_cell u_cell (
      .clk        (clk),
      .load       (state == S_TERM),
      .load_value ((k == 0) ? LIMB_W'(1) : LIMB_W'(0)),
      .shift      (state == S_MUL),
      .shift_in   (from_next),
      .limb       (limb[k])
    );
    assign prod_wide[k*LIMB_W +: LIMB_W] = limb[k];
  end

  // output indexing
  assign last_out = (int'(ei) == int'(n_run) - 1) && (int'(ej) == int'(n_run) - 1);
  assign ej_next  = (int'(ej) == int'(n_run) - 1) ? '0 : ej + 1'b1;
  assign ei_next  = (int'(ej) == int'(n_run) - 1) ? ei + 1'b1 : ei;

  assign m_tdata  = {(OUT_TDATA_W - ELEM_W - 2*IDX_OUT_W)'(0),
                     IDX_OUT_W'(ej), IDX_OUT_W'(ei), out_value};
  assign m_tlast  = last_out;
  assign m_tuser  = sing;

  // cofactor (i,j) is the minor without row j and column i
  assign dctl.start = (state == S_NEXT) && !is_det;
  assign dctl.flip  = ei[0] ^ ej[0];

  mia_divider #(.W(W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dctl),
    .num  (sum),
    .den  (det),
    .res  (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      order      <= ORDER_RESET;
      m_tvalid   <= 1'b0;
      is_det     <= 1'b0;
      sing       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        order <= pwdata[ORDER_W-1:0];
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (lc_inc >= total) begin
              load_count <= '0;
              n_run      <= n_eff;
              msize      <= n_eff;
              skip_row   <= NW'(MAX_ORDER);
              skip_col   <= NW'(MAX_ORDER);
              is_det     <= 1'b1;
              state      <= S_MINOR;
            end else begin
              load_count <= lc_inc;
            end
          end
        end
        S_MINOR: begin
          sum <= '0;
          for (int k = 0; k < MAX_ORDER; k++) begin
            dig[k] <= '0;
          end
          state <= S_TERM;
        end
        S_TERM: begin
          used     <= '0;
          level    <= '0;
          term_neg <= parity;
          state    <= S_READ;
        end
        S_READ: begin
          used[col] <= 1'b1;
          state     <= S_FACT;
        end
        S_FACT: begin
          mul_u     <= elem[ELEM_W-1] ? (~elem + 1'b1) : elem;
          term_neg  <= term_neg ^ elem[ELEM_W-1];
          mul_carry <= '0;
          mcnt      <= '0;
          state     <= S_MUL;
        end
        S_MUL: begin
          mul_carry <= head[2*LIMB_W-1:LIMB_W];
          mcnt      <= mcnt + 1'b1;
          if (mcnt == MCW'(LIMBS - 1)) begin
            level <= level + 1'b1;
            state <= (level == msize - 1'b1) ? S_ACC : S_READ;
          end
        end
        S_ACC: begin
          sum   <= term_neg ? sum - prod_wide : sum + prod_wide;
          dig   <= dig_next;
          state <= wrap ? S_NEXT : S_TERM;
        end
        S_NEXT: begin
          if (is_det) begin
            det  <= sum;
            sing <= (sum == '0);
            ei   <= '0;
            ej   <= '0;
            if (sum == '0) begin
              out_value <= '0;
              m_tvalid  <= 1'b1;
              state     <= S_OUT;
            end else begin
              is_det   <= 1'b0;
              msize    <= n_run - 1'b1;
              skip_row <= '0;
              skip_col <= '0;
              state    <= S_MINOR;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dres.done) begin
            out_value <= dres.quotient;
            m_tvalid  <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (last_out) begin
              m_tvalid <= 1'b0;
              state    <= S_LOAD;
            end else begin
              ei <= ei_next;
              ej <= ej_next;
              // singular: entries are all zero, keep streaming
              if (!sing) begin
                m_tvalid <= 1'b0;
                skip_row <= NW'(ej_next);
                skip_col <= NW'(ei_next);
                state    <= S_MINOR;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_div_when_waiting: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[ELEM_W-1:0] == '0))
    else $error("singular matrix gave a nonzero entry");

  a_reload_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready to load after the last entry");

endmodule

>>> test/matrix_inverse_by_adjugate_tb.sv
// Self-checking bench for matrix_inverse_by_adjugate: loads matrices over the
// element stream, sets the order over APB and checks every inverse entry.
// Depends on mia_pkg and the RTL of the block; nothing else.
module matrix_inverse_by_adjugate_tb;
  import mia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXN = MAX_ORDER_DEFAULT;

  typedef struct packed {
    logic [31:0] entry;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        singular;
    logic        last;
  } inv_entry_t;

  typedef struct {
    logic [2:0]  order_wr;   // order written before this row when do_cfg
    bit          do_cfg;
    logic [31:0] elem;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [ELEM_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [0:0] m_tuser;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  matrix_inverse_by_adjugate u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [31:0] mat_words [MAXN*MAXN];
  int          elems_loaded;
  logic [2:0]  order_reg;
  inv_entry_t  inverse_q [$];
  int          errors, matrices_done, entries_seen, singular_seen;
  bit          rx_stall_on;
  int          stall_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  // exact integers: 4x4 det of 32-bit words fits easily in 160 bits
  function automatic logic signed [199:0] minor_det(int n, int sr, int sc);
    logic signed [199:0] sum, prod;
    int perm [MAXN];
    int rows [MAXN], cols [MAXN];
    int m, r, c, k, i, j, t, inv, total;
    m = 0;
    for (r = 0; r < n; r++) if (r != sr) begin rows[m] = r; m++; end
    m = 0;
    for (c = 0; c < n; c++) if (c != sc) begin cols[m] = c; m++; end
    sum = 0;
    if (m == 0) return 1;
    total = 1;
    for (k = 2; k <= m; k++) total *= k;
    for (i = 0; i < m; i++) perm[i] = i;
    for (t = 0; t < total; t++) begin
      prod = 1;
      for (i = 0; i < m; i++)
        prod = prod * $signed(mat_words[rows[i]*n + cols[perm[i]]]);
      inv = 0;
      for (i = 0; i < m; i++)
        for (j = i + 1; j < m; j++) if (perm[i] > perm[j]) inv++;
      if (inv & 1) sum = sum - prod; else sum = sum + prod;
      // next lexicographic permutation
      i = m - 2;
      while (i >= 0 && perm[i] > perm[i+1]) i--;
      if (i >= 0) begin
        j = m - 1;
        while (perm[j] < perm[i]) j--;
        k = perm[i]; perm[i] = perm[j]; perm[j] = k;
        for (j = i + 1, k = m - 1; j < k; j++, k--) begin
          r = perm[j]; perm[j] = perm[k]; perm[k] = r;
        end
      end
    end
    return sum;
  endfunction

  task automatic load_element(logic [31:0] v);
    int n, i, j;
    logic signed [199:0] det, cof, q;
    inv_entry_t e;
    n = (order_reg < 2) ? 2 : (order_reg > MAXN) ? MAXN : order_reg;
    if (elems_loaded >= MAXN*MAXN) elems_loaded = 0;
    mat_words[elems_loaded] = v;
    elems_loaded++;
    if (elems_loaded < n*n) return;
    elems_loaded = 0;
    det = minor_det(n, n, n);
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) begin
        e.row = 2'(i); e.col = 2'(j); e.singular = (det == 0);
        e.last = (i*n + j == n*n - 1);
        e.entry = 32'(0);
        if (det != 0) begin
          cof = minor_det(n, j, i);
          if ((i + j) & 1) cof = -cof;
          q = (cof <<< 32) / det;  // truncates toward zero
          if (q > 200'sd2147483647) e.entry = 32'h7FFFFFFF;
          else if (q < -200'sd2147483648) e.entry = 32'h80000000;
          else e.entry = q[31:0];
        end
        inverse_q.push_back(e);
      end
  endtask

  task automatic apb_write_order(logic [2:0] v);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = 3'(4*REG_MATRIX_ORDER); pwdata = 32'(v);
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    order_reg = v;
  endtask

  task automatic wait_drained();
    while (inverse_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_element(logic [31:0] v);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    s_tvalid = 1; s_tdata = v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    load_element(v);
    @(negedge clk);
    s_tvalid = 0;
  endtask

  // result side: mostly short random stalls, now and then a long one
  always @(negedge clk) begin
    if (!rx_stall_on) begin
      m_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 39) == 0) begin
      stall_left = $urandom_range(10, 40);
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    inv_entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      entries_seen++;
      if (m_tuser[0]) singular_seen++;
      if (inverse_q.size() == 0) begin
        $error("inverse entry with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        e = inverse_q.pop_front();
        if (m_tdata[31:0] !== e.entry) begin
          $error("inverse_entry exp %h got %h", e.entry, m_tdata[31:0]); errors++;
        end
        if (m_tdata[33:32] !== e.row) begin
          $error("entry_row exp %0d got %0d", e.row, m_tdata[33:32]); errors++;
        end
        if (m_tdata[35:34] !== e.col) begin
          $error("entry_column exp %0d got %0d", e.col, m_tdata[35:34]); errors++;
        end
        if (m_tuser[0] !== e.singular) begin
          $error("singular exp %0d got %0d", e.singular, m_tuser[0]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_entry exp %0d got %0d", e.last, m_tlast); errors++;
        end
        if (e.last) matrices_done++;
      end
    end
  end

  stim_row_t directed [] = '{
    // identity 2x2 (order write of 0 clamps to 2)
    '{3'd0, 1, 32'h0001_0000}, '{3'd0, 0, 32'h0}, '{3'd0, 0, 32'h0},
    '{3'd0, 0, 32'h0001_0000},
    // singular 2x2
    '{3'd2, 1, 32'h7FFF_FFFF}, '{3'd2, 0, 32'h7FFF_FFFF},
    '{3'd2, 0, 32'h8000_0000}, '{3'd2, 0, 32'h8000_0000},
    // tiny det saturates
    '{3'd2, 0, 32'h0000_0001}, '{3'd2, 0, 32'h0}, '{3'd2, 0, 32'h0},
    '{3'd2, 0, 32'hFFFF_FFFF},
    // extremes, order 3
    '{3'd3, 1, 32'h8000_0000}, '{3'd3, 0, 32'h7FFF_FFFF}, '{3'd3, 0, 32'h1},
    '{3'd3, 0, 32'hFFFF_FFFF}, '{3'd3, 0, 32'h0002_0000}, '{3'd3, 0, 32'h0},
    '{3'd3, 0, 32'h0},         '{3'd3, 0, 32'h5555_AAAA}, '{3'd3, 0, 32'hAAAA_5555}
  };

  initial begin
    int i, k, n, cnt;
    logic [31:0] v;
    rst = 1; s_tvalid = 0; s_tdata = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    elems_loaded = 0; order_reg = ORDER_RESET; rx_stall_on = 0;
    foreach (mat_words[k]) mat_words[k] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed[i]) begin
      if (directed[i].do_cfg) begin
        // order changes only once the previous inverse is out
        wait_drained();
        apb_write_order(directed[i].order_wr);
      end
      send_element(directed[i].elem);
    end
    // let the order-3 inverse drain before random traffic
    wait_drained();
    rx_stall_on = 1;

    // random: full matrices, order sweep including out-of-range 7 and 1
    cnt = 0;
    while (cnt < 190) begin
      wait_drained();
      repeat (4500) @(negedge clk);
      k = $urandom_range(0, 9);
      apb_write_order(k < 3 ? 3'd2 : k < 6 ? 3'd3 : k < 8 ? 3'd4 : k == 8 ? 3'd7 : 3'd1);
      n = (order_reg < 2) ? 2 : (order_reg > MAXN) ? MAXN : order_reg;
      for (i = 0; i < n*n; i++) begin
        case ($urandom_range(0, 5))
          0: v = $urandom;
          1: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
          2: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
          3: v = (i % (n+1) == 0) ? 32'h0001_0000 : 32'h0; // near identity
          default: v = $signed(32'($urandom_range(0, 16)) - 32'd8) <<< 16;
        endcase
        // occasional duplicate row to force a singular matrix
        if (k == 5 && i >= n && i < 2*n) v = mat_words[i - n];
        send_element(v);
        cnt++;
      end
    end
    wait_drained();
    repeat (6000) @(negedge clk);
    $display("Checked %0d matrices, %0d inverse entries (%0d singular).",
             matrices_done, entries_seen, singular_seen);
    $display("Orders 2..4 with clamped register values, stalls on both sides.");
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
